// ----- sv/rcn_pkg.sv -----
// Shared types, constants and helpers for the RMS contrast normaliser.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rcn_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int CHANNELS    = 3;
    localparam int CH_W        = 2;
    localparam int DIM_W       = 13;
    localparam int PIX_W       = 16;
    localparam int CNT_W       = 24;
    localparam int N_W         = 25;
    localparam int SUM_W       = 40;
    localparam int SQ_W        = 56;
    localparam int MEAN_W      = SUM_W + 1;
    localparam int INV_W       = 32;
    localparam int PROD_W      = PIX_W + INV_W;
    localparam int OUT_W       = 16;
    localparam int ACC_W       = 82;
    localparam int N2_W        = 49;
    localparam int N2_SHIFT    = 54;
    localparam int DVD_W       = N2_W + N2_SHIFT;
    localparam int ROOT_W      = 64;
    localparam int STEP_W      = 7;
    localparam int MUL_STEPS   = SUM_W;
    localparam int ROOT_STEPS  = ROOT_W / 2;
    localparam int ROUND_SHIFT = 17;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic MODE_STATS = 1'b0;
    localparam logic MODE_NORM  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] red_out;
        logic signed [OUT_W-1:0] green_out;
        logic signed [OUT_W-1:0] blue_out;
        logic [CHANNELS-1:0]     flat_mask;
        logic                    clipped;
        logic                    not_ready;
    } pixel_out_t;

    typedef struct packed {
        logic             start;
        logic [N_W-1:0]   count;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  square_sum;
    } solve_req_t;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] mean;
        logic [INV_W-1:0] inv_sigma;
        logic             zero;
    } solve_rsp_t;

    typedef enum logic [2:0] {
        SV_IDLE, SV_MEAN, SV_MUL, SV_CHECK, SV_DIV, SV_ROOT, SV_DONE
    } solve_state_t;

    typedef enum logic [2:0] {
        EN_IDLE, EN_MUL, EN_FIN, EN_START, EN_WAIT
    } engine_state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rcn_front.sv -----
// Input queue of the normaliser: takes pixel words and holds them for the engine.
// Depends on rcn_pkg.
`default_nettype none

module rcn_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rcn_pkg::pixel_in_t in_data,
    output logic                   out_valid,
    input  wire logic              out_pop,
    output rcn_pkg::pixel_in_t     out_data
);

    rcn_pkg::pixel_in_t               entry_reg [rcn_pkg::FIFO_DEPTH];
    logic [rcn_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [rcn_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [rcn_pkg::FIFO_AW:0]        count_reg;
    logic [rcn_pkg::FIFO_AW:0]        count_next;
    logic                             push;
    logic                             pop;

    assign in_ready  = (count_reg != (rcn_pkg::FIFO_AW+1)'(rcn_pkg::FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rcn_solver.sv -----
// Frame-end statistics unit: mean, variance numerator and reciprocal sigma of one channel.
// Shift-add multiplier, restoring divider and digit-by-digit square root. Depends on rcn_pkg.
`default_nettype none

module rcn_solver (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rcn_pkg::solve_req_t req,
    output rcn_pkg::solve_rsp_t      rsp
);

    rcn_pkg::solve_state_t             state_reg;
    rcn_pkg::solve_state_t             state_next;
    logic [rcn_pkg::STEP_W-1:0]        step_reg;
    logic [rcn_pkg::N_W-1:0]           n_reg;
    logic [rcn_pkg::SUM_W-1:0]         s1_reg;
    logic [rcn_pkg::SQ_W-1:0]          s2_reg;
    logic [rcn_pkg::DVD_W-1:0]         dvd_reg;
    logic [rcn_pkg::ACC_W-1:0]         dvs_reg;
    logic [rcn_pkg::ACC_W-1:0]         rem_reg;
    logic [rcn_pkg::DVD_W-1:0]         quo_reg;
    logic [rcn_pkg::ACC_W-1:0]         a_reg;
    logic [rcn_pkg::ACC_W-1:0]         b_reg;
    logic [rcn_pkg::SUM_W-1:0]         mpn_reg;
    logic [rcn_pkg::SUM_W-1:0]         mps_reg;
    logic [rcn_pkg::N2_W-1:0]          n2_reg;
    logic [rcn_pkg::PIX_W-1:0]         mean_reg;
    logic [rcn_pkg::INV_W-1:0]         inv_reg;
    logic                              zero_reg;
    logic                              sat_reg;
    logic [rcn_pkg::ROOT_W-1:0]        rv_reg;
    logic [rcn_pkg::ROOT_W-1:0]        rres_reg;
    logic [rcn_pkg::ROOT_W-1:0]        rbit_reg;

    logic [rcn_pkg::ACC_W:0]           rem_sh;
    logic                              div_ge;
    logic [rcn_pkg::ACC_W-1:0]         rem_next;
    logic [rcn_pkg::DVD_W-1:0]         quo_next;
    logic [rcn_pkg::ACC_W-1:0]         a_next;
    logic [rcn_pkg::ACC_W-1:0]         b_next;
    logic [rcn_pkg::ROOT_W-1:0]        root_t;
    logic                              root_ge;
    logic [rcn_pkg::ROOT_W-1:0]        rv_next;
    logic [rcn_pkg::ROOT_W-1:0]        rres_next;
    logic [rcn_pkg::MEAN_W-1:0]        sum_half;
    logic                              last_step;

    assign last_step = (step_reg == '0);
    assign sum_half  = rcn_pkg::MEAN_W'(req.sum) + rcn_pkg::MEAN_W'(req.count >> 1);

    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[rcn_pkg::DVD_W-1]};
        div_ge   = (rem_sh >= {1'b0, dvs_reg});
        rem_next = div_ge ? rcn_pkg::ACC_W'(rem_sh - {1'b0, dvs_reg})
                          : rem_sh[rcn_pkg::ACC_W-1:0];
        quo_next = {quo_reg[rcn_pkg::DVD_W-2:0], div_ge};

        a_next = {a_reg[rcn_pkg::ACC_W-2:0], 1'b0}
               + (mpn_reg[rcn_pkg::SUM_W-1] ? rcn_pkg::ACC_W'(s2_reg) : '0);
        b_next = {b_reg[rcn_pkg::ACC_W-2:0], 1'b0}
               + (mps_reg[rcn_pkg::SUM_W-1] ? rcn_pkg::ACC_W'(s1_reg) : '0);

        root_t    = rres_reg + rbit_reg;
        root_ge   = (rv_reg >= root_t);
        rv_next   = root_ge ? rv_reg - root_t : rv_reg;
        rres_next = root_ge ? (rres_reg >> 1) + rbit_reg : rres_reg >> 1;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rcn_pkg::SV_IDLE: begin
                if (req.start) begin
                    state_next = rcn_pkg::SV_MEAN;
                end
            end
            rcn_pkg::SV_MEAN: begin
                if (last_step) begin
                    state_next = rcn_pkg::SV_MUL;
                end
            end
            rcn_pkg::SV_MUL: begin
                if (last_step) begin
                    state_next = rcn_pkg::SV_CHECK;
                end
            end
            rcn_pkg::SV_CHECK: begin
                state_next = (a_reg <= b_reg) ? rcn_pkg::SV_DONE : rcn_pkg::SV_DIV;
            end
            rcn_pkg::SV_DIV: begin
                if (last_step) begin
                    state_next = rcn_pkg::SV_ROOT;
                end
            end
            rcn_pkg::SV_ROOT: begin
                if (last_step) begin
                    state_next = rcn_pkg::SV_DONE;
                end
            end
            rcn_pkg::SV_DONE: begin
                state_next = rcn_pkg::SV_IDLE;
            end
            default: begin
                state_next = rcn_pkg::SV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcn_pkg::SV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            rcn_pkg::SV_IDLE: begin
                n_reg    <= req.count;
                s1_reg   <= req.sum;
                s2_reg   <= req.square_sum;
                dvd_reg  <= {sum_half, {(rcn_pkg::DVD_W-rcn_pkg::MEAN_W){1'b0}}};
                dvs_reg  <= rcn_pkg::ACC_W'(req.count);
                rem_reg  <= '0;
                quo_reg  <= '0;
                step_reg <= rcn_pkg::STEP_W'(rcn_pkg::MEAN_W - 1);
            end
            rcn_pkg::SV_MEAN: begin
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                dvd_reg  <= dvd_reg << 1;
                step_reg <= step_reg - 1'b1;
                if (last_step) begin
                    mean_reg <= (|quo_next[rcn_pkg::MEAN_W-1:rcn_pkg::PIX_W])
                              ? '1 : quo_next[rcn_pkg::PIX_W-1:0];
                    a_reg    <= '0;
                    b_reg    <= '0;
                    mpn_reg  <= rcn_pkg::SUM_W'(n_reg);
                    mps_reg  <= s1_reg;
                    n2_reg   <= rcn_pkg::N2_W'(n_reg) * rcn_pkg::N2_W'(n_reg);
                    step_reg <= rcn_pkg::STEP_W'(rcn_pkg::MUL_STEPS - 1);
                end
            end
            rcn_pkg::SV_MUL: begin
                a_reg    <= a_next;
                b_reg    <= b_next;
                mpn_reg  <= mpn_reg << 1;
                mps_reg  <= mps_reg << 1;
                step_reg <= step_reg - 1'b1;
            end
            rcn_pkg::SV_CHECK: begin
                zero_reg <= (a_reg <= b_reg);
                inv_reg  <= '0;
                dvs_reg  <= a_reg - b_reg;
                dvd_reg  <= {n2_reg, {rcn_pkg::N2_SHIFT{1'b0}}};
                rem_reg  <= '0;
                quo_reg  <= '0;
                step_reg <= rcn_pkg::STEP_W'(rcn_pkg::DVD_W - 1);
            end
            rcn_pkg::SV_DIV: begin
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                dvd_reg  <= dvd_reg << 1;
                step_reg <= step_reg - 1'b1;
                if (last_step) begin
                    sat_reg  <= |quo_next[rcn_pkg::DVD_W-1:rcn_pkg::ROOT_W];
                    rv_reg   <= quo_next[rcn_pkg::ROOT_W-1:0];
                    rres_reg <= '0;
                    rbit_reg <= rcn_pkg::ROOT_W'(1) << (rcn_pkg::ROOT_W - 2);
                    step_reg <= rcn_pkg::STEP_W'(rcn_pkg::ROOT_STEPS - 1);
                end
            end
            rcn_pkg::SV_ROOT: begin
                rv_reg   <= rv_next;
                rres_reg <= rres_next;
                rbit_reg <= rbit_reg >> 2;
                step_reg <= step_reg - 1'b1;
                if (last_step) begin
                    inv_reg <= sat_reg ? '1 : rres_next[rcn_pkg::INV_W-1:0];
                end
            end
            default: begin
                step_reg <= step_reg;
            end
        endcase
    end

    assign rsp.done      = (state_reg == rcn_pkg::SV_DONE);
    assign rsp.mean      = mean_reg;
    assign rsp.inv_sigma = inv_reg;
    assign rsp.zero      = zero_reg;

endmodule

`default_nettype wire

// ----- sv/rcn_engine.sv -----
// Back end of the normaliser: statistics accumulation, frame-end sequencing,
// normalisation arithmetic and the result register. Depends on rcn_pkg.
`default_nettype none

module rcn_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [rcn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rcn_pkg::DIM_W-1:0]     cfg_data,
    input  wire logic                          q_valid,
    input  wire rcn_pkg::pixel_in_t            q_data,
    output logic                               q_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output rcn_pkg::pixel_out_t                m_data,
    output rcn_pkg::solve_req_t                solve_req,
    input  wire rcn_pkg::solve_rsp_t           solve_rsp
);

    rcn_pkg::engine_state_t             state_reg;
    rcn_pkg::engine_state_t             state_next;
    logic [rcn_pkg::DIM_W-1:0]          width_reg;
    logic [rcn_pkg::DIM_W-1:0]          height_reg;
    logic [rcn_pkg::SUM_W-1:0]          sum_reg   [rcn_pkg::CHANNELS];
    logic [rcn_pkg::SQ_W-1:0]           sq_reg    [rcn_pkg::CHANNELS];
    logic [rcn_pkg::CNT_W-1:0]          cnt_reg;
    logic [rcn_pkg::N_W-1:0]            count_reg;
    logic [rcn_pkg::PIX_W-1:0]          mean_reg  [rcn_pkg::CHANNELS];
    logic [rcn_pkg::INV_W-1:0]          inv_reg   [rcn_pkg::CHANNELS];
    logic [rcn_pkg::CHANNELS-1:0]       zero_reg;
    logic                               stats_reg;
    logic [rcn_pkg::CH_W-1:0]           ch_reg;
    logic [rcn_pkg::PIX_W-1:0]          diff_reg  [rcn_pkg::CHANNELS];
    logic [rcn_pkg::CHANNELS-1:0]       neg_reg;
    logic [rcn_pkg::PROD_W-1:0]         prod_reg  [rcn_pkg::CHANNELS];
    logic                               nr_reg;
    logic                               out_valid_reg;
    rcn_pkg::pixel_out_t                out_reg;

    logic [rcn_pkg::PIX_W-1:0]          x [rcn_pkg::CHANNELS];
    logic [rcn_pkg::N_W-1:0]            total;
    logic [rcn_pkg::N_W-1:0]            count_next;
    logic                               frame_end;
    logic                               out_load;
    logic                               cfg_hit;
    logic signed [rcn_pkg::OUT_W-1:0]   res [rcn_pkg::CHANNELS];
    logic [rcn_pkg::CHANNELS-1:0]       clip_bits;
    logic [rcn_pkg::PROD_W:0]           rnd [rcn_pkg::CHANNELS];
    logic [rcn_pkg::INV_W-1:0]          mag [rcn_pkg::CHANNELS];
    rcn_pkg::pixel_out_t                out_next;

    assign x[0] = q_data.red_in;
    assign x[1] = q_data.green_in;
    assign x[2] = q_data.blue_in;

    assign total      = rcn_pkg::N_W'(width_reg) * rcn_pkg::N_W'(height_reg);
    assign count_next = rcn_pkg::N_W'(cnt_reg) + 1'b1;
    assign frame_end  = (count_next >= total);
    assign cfg_hit    = cfg_we && (cfg_index == rcn_pkg::REG_WIDTH
                                   || cfg_index == rcn_pkg::REG_HEIGHT);

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            rcn_pkg::EN_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_data.mode == rcn_pkg::MODE_NORM) begin
                        state_next = rcn_pkg::EN_MUL;
                    end else if (frame_end) begin
                        state_next = rcn_pkg::EN_START;
                    end
                end
            end
            rcn_pkg::EN_MUL: begin
                state_next = rcn_pkg::EN_FIN;
            end
            rcn_pkg::EN_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = rcn_pkg::EN_IDLE;
                end
            end
            rcn_pkg::EN_START: begin
                state_next = rcn_pkg::EN_WAIT;
            end
            rcn_pkg::EN_WAIT: begin
                if (solve_rsp.done) begin
                    state_next = (ch_reg == rcn_pkg::CH_W'(rcn_pkg::CHANNELS - 1))
                               ? rcn_pkg::EN_IDLE : rcn_pkg::EN_START;
                end
            end
            default: begin
                state_next = rcn_pkg::EN_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int c = 0; c < rcn_pkg::CHANNELS; c++) begin
            rnd[c] = {1'b0, prod_reg[c]} + ((rcn_pkg::PROD_W+1)'(1) << (rcn_pkg::ROUND_SHIFT-1));
            mag[c] = rnd[c][rcn_pkg::PROD_W:rcn_pkg::ROUND_SHIFT];
            clip_bits[c] = 1'b0;
            if (zero_reg[c] || nr_reg) begin
                res[c] = '0;
            end else if (!neg_reg[c]) begin
                if (mag[c] > rcn_pkg::INV_W'(32767)) begin
                    res[c]       = 16'sh7FFF;
                    clip_bits[c] = 1'b1;
                end else begin
                    res[c] = mag[c][rcn_pkg::OUT_W-1:0];
                end
            end else begin
                if (mag[c] > rcn_pkg::INV_W'(32768)) begin
                    res[c]       = 16'sh8000;
                    clip_bits[c] = 1'b1;
                end else begin
                    res[c] = rcn_pkg::OUT_W'(0 - mag[c][rcn_pkg::OUT_W:0]);
                end
            end
        end
        out_next.red_out   = res[0];
        out_next.green_out = res[1];
        out_next.blue_out  = res[2];
        out_next.flat_mask = nr_reg ? '0 : zero_reg;
        out_next.clipped   = |clip_bits;
        out_next.not_ready = nr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcn_pkg::EN_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= rcn_pkg::DIM_W'(1);
            height_reg    <= rcn_pkg::DIM_W'(1);
            cnt_reg       <= '0;
            zero_reg      <= '0;
            stats_reg     <= 1'b0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < rcn_pkg::CHANNELS; c++) begin
                sum_reg[c]  <= '0;
                sq_reg[c]   <= '0;
                mean_reg[c] <= '0;
                inv_reg[c]  <= '0;
            end
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_hit) begin
                if (cfg_index == rcn_pkg::REG_WIDTH) begin
                    width_reg <= rcn_pkg::clamp_dim(cfg_data);
                end else begin
                    height_reg <= rcn_pkg::clamp_dim(cfg_data);
                end
                cnt_reg <= '0;
                for (int c = 0; c < rcn_pkg::CHANNELS; c++) begin
                    sum_reg[c] <= '0;
                    sq_reg[c]  <= '0;
                end
            end else if (state_reg == rcn_pkg::EN_IDLE && q_valid
                         && q_data.mode == rcn_pkg::MODE_STATS) begin
                for (int c = 0; c < rcn_pkg::CHANNELS; c++) begin
                    sum_reg[c] <= sum_reg[c] + rcn_pkg::SUM_W'(x[c]);
                    sq_reg[c]  <= sq_reg[c] + rcn_pkg::SQ_W'(x[c]) * rcn_pkg::SQ_W'(x[c]);
                end
                if (frame_end) begin
                    ch_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end else if (state_reg == rcn_pkg::EN_WAIT && solve_rsp.done) begin
                mean_reg[ch_reg] <= solve_rsp.mean;
                inv_reg[ch_reg]  <= solve_rsp.inv_sigma;
                zero_reg[ch_reg] <= solve_rsp.zero;
                if (ch_reg == rcn_pkg::CH_W'(rcn_pkg::CHANNELS - 1)) begin
                    stats_reg <= 1'b1;
                    cnt_reg   <= '0;
                    for (int c = 0; c < rcn_pkg::CHANNELS; c++) begin
                        sum_reg[c] <= '0;
                        sq_reg[c]  <= '0;
                    end
                end else begin
                    ch_reg <= ch_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == rcn_pkg::EN_IDLE && q_valid) begin
            count_reg <= count_next;
            nr_reg    <= !stats_reg;
            for (int c = 0; c < rcn_pkg::CHANNELS; c++) begin
                neg_reg[c]  <= (x[c] < mean_reg[c]);
                diff_reg[c] <= (x[c] < mean_reg[c]) ? mean_reg[c] - x[c]
                                                    : x[c] - mean_reg[c];
            end
        end
        if (state_reg == rcn_pkg::EN_MUL) begin
            for (int c = 0; c < rcn_pkg::CHANNELS; c++) begin
                prod_reg[c] <= rcn_pkg::PROD_W'(diff_reg[c]) * rcn_pkg::PROD_W'(inv_reg[c]);
            end
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign solve_req.start      = (state_reg == rcn_pkg::EN_START);
    assign solve_req.count      = count_reg;
    assign solve_req.sum        = sum_reg[ch_reg];
    assign solve_req.square_sum = sq_reg[ch_reg];

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ----- sv/rms_contrast_normalize.sv -----
// RMS contrast normaliser for RGB pixels over two passes of a frame.
// Top level: input queue, statistics unit and engine. Depends on rcn_pkg and its modules.
//
// Usage: pixel words arrive on s_valid/s_ready, results leave on m_valid/m_ready.
// A word with mode 0 adds to the per-channel sums and produces no result; after
// image_width * image_height such words the mean and reciprocal sigma are latched.
// A word with mode 1 produces one normalised result in signed Q5.10.
// Statistics words are consumed at one per cycle while the engine is idle. A
// normalise word passes through the engine's difference, multiply, and round and
// saturate steps into the result register; the next word is taken only after that.
// At the end of a frame the shared multiply, divide and square-root unit runs per
// channel: 41 divide, 40 multiply, 103 divide and 32 root steps, the last two
// skipped for a flat channel, while words wait in the four-entry input queue.
// Reset clears the sums, the counter and the latched statistics; width and height
// return to 1. When the receiver stalls the result register holds its word and
// the engine holds its next result; the queue keeps accepting words until it is full.
// Configuration writes to width or height on cfg_we/cfg_index/cfg_data take effect
// at once and restart the statistics pass.
`default_nettype none

module rms_contrast_normalize (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire rcn_pkg::pixel_in_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output rcn_pkg::pixel_out_t                m_data,
    input  wire logic                          cfg_we,
    input  wire logic [rcn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rcn_pkg::DIM_W-1:0]     cfg_data
);

    logic                q_valid;
    logic                q_pop;
    rcn_pkg::pixel_in_t  q_data;
    rcn_pkg::solve_req_t solve_req;
    rcn_pkg::solve_rsp_t solve_rsp;

    rcn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (q_data)
    );

    rcn_solver u_solver (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (solve_req),
        .rsp     (solve_rsp)
    );

    rcn_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .solve_req (solve_req),
        .solve_rsp (solve_rsp)
    );

`ifndef ASSERT_OFF
    a_not_ready_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.not_ready |-> m_data.flat_mask == '0 && !m_data.clipped
            && m_data.red_out == '0 && m_data.green_out == '0 && m_data.blue_out == '0)
        else $error("not-ready result carries data");

    a_flat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.flat_mask[0] || m_data.flat_mask[1] || m_data.flat_mask[2])
            |-> (!m_data.flat_mask[0] || m_data.red_out == '0)
             && (!m_data.flat_mask[1] || m_data.green_out == '0)
             && (!m_data.flat_mask[2] || m_data.blue_out == '0))
        else $error("flat channel has a non-zero output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result or full queue after reset");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the RMS contrast normaliser (rms_contrast_normalize).
// It predicts each normalised word from its own model of the frame statistics and
// checks the result stream in order; it depends on rcn_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
    import rcn_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    pixel_in_t            s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    pixel_out_t           m_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    rms_contrast_normalize dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    int unsigned          tx_idle_pct = 0;
    int unsigned          rx_idle_pct = 0;
    pixel_out_t           expected_words[$];
    int unsigned          mismatches = 0;
    int unsigned          words_sent = 0;
    int unsigned          words_checked = 0;
    int unsigned          frames_latched = 0;

    // Predictor state.
    int unsigned          frame_w = 1;
    int unsigned          frame_h = 1;
    logic [SUM_W-1:0]     acc_sum [CHANNELS];
    logic [SQ_W-1:0]      acc_sq [CHANNELS];
    int unsigned          acc_count = 0;
    logic [PIX_W-1:0]     lat_mean [CHANNELS];
    logic [INV_W-1:0]     lat_inv [CHANNELS];
    logic [CHANNELS-1:0]  lat_flat = '0;
    logic                 lat_valid = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("tb NOT OK");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", m_data);
            end else begin
                pixel_out_t e;
                e = expected_words.pop_front();
                words_checked++;
                if (e !== m_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected r%h g%h b%h f%b c%b n%b, got r%h g%h b%h f%b c%b n%b",
                                 e.red_out, e.green_out, e.blue_out, e.flat_mask, e.clipped,
                                 e.not_ready, m_data.red_out, m_data.green_out,
                                 m_data.blue_out, m_data.flat_mask, m_data.clipped,
                                 m_data.not_ready);
                end
            end
        end
    end

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void clear_frame_sums();
        for (int c = 0; c < CHANNELS; c++) begin
            acc_sum[c] = '0;
            acc_sq[c] = '0;
        end
        acc_count = 0;
    endfunction

    function automatic void latch_frame_stats(input int unsigned n);
        logic [127:0] a, b, d, dvd, q;
        logic [63:0]  m;
        logic [63:0]  root;
        lat_flat = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            m = (64'(acc_sum[c]) + 64'(n / 2)) / 64'(n);
            lat_mean[c] = (m > 64'hFFFF) ? 16'hFFFF : m[15:0];
            a = 128'(n) * 128'(acc_sq[c]);
            b = 128'(acc_sum[c]) * 128'(acc_sum[c]);
            if (a <= b) begin
                lat_inv[c] = '0;
                lat_flat[c] = 1'b1;
            end else begin
                d = a - b;
                dvd = (128'(n) * 128'(n)) << N2_SHIFT;
                q = dvd / d;
                root = root_floor(q[63:0]);
                lat_inv[c] = (q[127:64] != 0) ? 32'hFFFFFFFF : root[31:0];
            end
        end
        lat_valid = 1'b1;
        frames_latched++;
    endfunction

    function automatic void predict_word(input pixel_in_t p);
        logic [PIX_W-1:0] x [CHANNELS];
        logic [63:0]      diff, mag;
        logic             neg;
        pixel_out_t       r;
        x[0] = p.red_in;
        x[1] = p.green_in;
        x[2] = p.blue_in;
        if (p.mode == MODE_STATS) begin
            for (int c = 0; c < CHANNELS; c++) begin
                acc_sum[c] += SUM_W'(x[c]);
                acc_sq[c] += SQ_W'(32'(x[c]) * 32'(x[c]));
            end
            if (acc_count + 1 >= frame_w * frame_h) begin
                latch_frame_stats(acc_count + 1);
                clear_frame_sums();
            end else begin
                acc_count++;
            end
            return;
        end
        r = '0;
        if (!lat_valid) begin
            r.not_ready = 1'b1;
        end else begin
            for (int c = 0; c < CHANNELS; c++) begin
                logic [15:0] v;
                v = '0;
                if (!lat_flat[c]) begin
                    neg = x[c] < lat_mean[c];
                    diff = neg ? 64'(lat_mean[c] - x[c]) : 64'(x[c] - lat_mean[c]);
                    mag = (diff * 64'(lat_inv[c]) + (64'd1 << 16)) >> ROUND_SHIFT;
                    if (!neg) begin
                        if (mag > 32767) begin
                            mag = 32767;
                            r.clipped = 1'b1;
                        end
                        v = mag[15:0];
                    end else begin
                        if (mag > 32768) begin
                            mag = 32768;
                            r.clipped = 1'b1;
                        end
                        v = 16'(0 - mag);
                    end
                end
                case (c)
                    0: r.red_out = v;
                    1: r.green_out = v;
                    default: r.blue_out = v;
                endcase
            end
            r.flat_mask = lat_flat;
        end
        expected_words.push_back(r);
    endfunction

    task automatic send_word(input logic mode, input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b);
        pixel_in_t p;
        logic      rdy;
        p.mode = mode;
        p.red_in = r;
        p.green_in = g;
        p.blue_in = b;
        s_valid <= 1'b1;
        s_data <= p;
        forever begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
            if (rdy) break;
        end
        predict_word(p);
        words_sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    // The frame-end solve can still be running after the last result, so allow for it.
    task automatic wait_idle();
        wait_results();
        repeat (900) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
            if (idx == REG_WIDTH) frame_w = (val == 0) ? 1 : (val > MAX_DIM) ? MAX_DIM : val;
            else frame_h = (val == 0) ? 1 : (val > MAX_DIM) ? MAX_DIM : val;
            clear_frame_sums();
        end
    endtask

    function automatic logic [15:0] pick_value(input int kind, input logic [15:0] base);
        case (kind)
            0: return 16'($urandom);
            1: return base;
            2: return base + 16'($urandom_range(0, 2));
            default: return ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic stats_pass(input int unsigned n, input int kind);
        logic [15:0] br, bg, bb;
        br = 16'($urandom);
        bg = 16'($urandom);
        bb = 16'($urandom);
        for (int unsigned i = 0; i < n; i++) begin
            send_word(MODE_STATS, pick_value(kind, br), pick_value($urandom_range(3), bg),
                      pick_value(kind, bb));
        end
    endtask

    task automatic test_not_ready();
        send_word(MODE_NORM, 16'h0000, 16'hFFFF, 16'h8000);
        send_word(MODE_NORM, 16'hFFFF, 16'h0000, 16'h0001);
        wait_idle();
    endtask

    task automatic test_flat_and_saturation();
        write_reg(REG_WIDTH, 13'd2);
        write_reg(REG_HEIGHT, 13'd1);
        send_word(MODE_STATS, 16'd0, 16'd5, 16'd0);
        send_word(MODE_STATS, 16'd1, 16'd5, 16'hFFFF);
        send_word(MODE_NORM, 16'hFFFF, 16'd5, 16'd0);
        send_word(MODE_NORM, 16'd0, 16'd0, 16'hFFFF);
        send_word(MODE_NORM, 16'd1, 16'hFFFF, 16'h8000);
        wait_idle();
    endtask

    task automatic test_interleave();
        write_reg(REG_WIDTH, 13'd3);
        send_word(MODE_STATS, 16'h1234, 16'h0000, 16'hFFFF);
        send_word(MODE_NORM, 16'h4000, 16'h4000, 16'h4000);
        send_word(MODE_STATS, 16'h8000, 16'h0100, 16'h0000);
        send_word(MODE_NORM, 16'h0000, 16'hFFFF, 16'h7FFF);
        send_word(MODE_STATS, 16'h0001, 16'h0200, 16'h0F0F);
        send_word(MODE_NORM, 16'h4000, 16'h4000, 16'h4000);
        wait_idle();
    endtask

    task automatic test_register_corners();
        write_reg(2'd2, 13'd7);
        write_reg(2'd3, 13'h1FFF);
        write_reg(REG_WIDTH, 13'd0);
        send_word(MODE_STATS, 16'hABCD, 16'h0000, 16'hFFFF);
        send_word(MODE_NORM, 16'hABCD, 16'h0001, 16'hFFFE);
        wait_idle();
    endtask

    // Large frames are only partly filled here, so the earlier statistics must stay in use.
    task automatic test_dimension_limits();
        write_reg(REG_WIDTH, 13'h1FFF);
        write_reg(REG_HEIGHT, 13'd1);
        stats_pass(150, 0);
        send_word(MODE_NORM, 16'h0000, 16'hFFFF, 16'h8000);
        wait_idle();
        write_reg(REG_WIDTH, 13'd1);
        write_reg(REG_HEIGHT, 13'd4096);
        stats_pass(150, 2);
        send_word(MODE_NORM, 16'hFFFF, 16'h0000, 16'h7FFF);
        wait_idle();
    endtask

    task automatic test_random_frames(input int unsigned tx_pct, input int unsigned rx_pct,
                                      input int unsigned quota);
        int unsigned start;
        int unsigned w, h, k;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = words_sent;
        while (words_sent - start < quota) begin
            w = $urandom_range(1, 5);
            h = $urandom_range(1, 4);
            write_reg(REG_WIDTH, 13'(w));
            write_reg(REG_HEIGHT, 13'(h));
            if ($urandom_range(9) == 0) begin
                stats_pass($urandom_range(0, w * h), $urandom_range(3));
            end else begin
                k = $urandom_range(0, w * h - 1);
                stats_pass(k, $urandom_range(3));
                if ($urandom_range(3) == 0) send_word(MODE_NORM, 16'($urandom),
                                                      16'($urandom), 16'($urandom));
                stats_pass(w * h - k, $urandom_range(3));
            end
            repeat ($urandom_range(1, 12)) begin
                send_word(MODE_NORM, 16'($urandom), 16'($urandom), 16'($urandom));
            end
            if ($urandom_range(4) == 0) wait_results();
            wait_idle();
        end
    endtask

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            lat_mean[c] = '0;
            lat_inv[c] = '0;
        end
        clear_frame_sums();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_not_ready();
        test_flat_and_saturation();
        test_interleave();
        test_register_corners();
        test_dimension_limits();
        test_random_frames(34, 64, 290);
        test_random_frames(64, 34, 290);
        test_random_frames(0, 0, 290);
        wait_idle();
        $display("Sent %0d words over %0d latched frames; checked %0d normalised words.",
                 words_sent, frames_latched, words_checked);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("%0d mismatches, %0d words outstanding", mismatches,
                     expected_words.size());
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/rcn_pkg.sv
sv/rcn_front.sv
sv/rcn_solver.sv
sv/rcn_engine.sv
sv/rms_contrast_normalize.sv
tb/tb.sv
